// ===== hdl/restoring_unsigned_divider_unit_defines.svh =====
// assertion macros for the restoring unsigned divider
// no dependencies; taken in by the files that assert
`ifndef RESTORING_UNSIGNED_DIVIDER_UNIT_DEFINES_SVH
`define RESTORING_UNSIGNED_DIVIDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define RUDU_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rudu assertion failed");

// checked at every edge, reset included
`define RUDU_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rudu assertion failed");

`else

`define RUDU_ASSERT_RST(label, clk, rst_n, prop)
`define RUDU_ASSERT_ALL(label, clk, prop)

`endif

`endif

// ===== hdl/rudu_pkg.sv =====
// types and constants of the restoring unsigned divider
// no dependencies
`default_nettype none

package rudu_pkg;

    localparam int DIV_W   = 32;
    localparam int FIELD_W = 32;

    typedef logic [DIV_W-1:0]   t_word;
    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        t_field dividend;
        t_field divisor;
    } t_div_in;

    typedef struct packed {
        t_field quotient;
        t_field remainder;
    } t_div_out;

    // partial remainder, shifting dividend/quotient word, divisor
    typedef struct packed {
        t_word rem;
        t_word quo;
        t_word dsr;
    } t_stage;

endpackage

`default_nettype wire

// ===== hdl/rudu_cell.sv =====
// one subtract-restore round of the divider chain with its stage register
// depends on rudu_pkg and restoring_unsigned_divider_unit_defines.svh
`default_nettype none
`include "restoring_unsigned_divider_unit_defines.svh"

module rudu_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_up_valid,
    output logic                 o_up_ready,
    input  wire rudu_pkg::t_stage i_up_stage,
    output logic                 o_dn_valid,
    input  wire logic            i_dn_ready,
    output rudu_pkg::t_stage     o_dn_stage
);

    logic                      r_valid;
    logic                      n_valid;
    rudu_pkg::t_stage          r_stage;
    rudu_pkg::t_stage          n_stage;
    logic [rudu_pkg::DIV_W:0]   shifted;
    logic [rudu_pkg::DIV_W+1:0] diff;
    logic                      take;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign o_dn_valid = r_valid;
    assign o_dn_stage = r_stage;

    always_comb begin
        shifted = {i_up_stage.rem, i_up_stage.quo[rudu_pkg::DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_up_stage.dsr};
        take    = !diff[rudu_pkg::DIV_W+1];
        n_stage.rem = take ? diff[rudu_pkg::DIV_W-1:0] : shifted[rudu_pkg::DIV_W-1:0];
        n_stage.quo = {i_up_stage.quo[rudu_pkg::DIV_W-2:0], take};
        n_stage.dsr = i_up_stage.dsr;
        n_valid     = o_up_ready ? i_up_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_up_ready && i_up_valid) begin
            r_stage <= n_stage;
        end
    end

    // a held transaction keeps its contents
    `RUDU_ASSERT_RST(a_stall_hold, i_clk, i_rst_n,
        r_valid && !i_dn_ready |=> r_valid && $stable(r_stage))
    // partial remainder stays below a nonzero divisor
    `RUDU_ASSERT_RST(a_rem_bound, i_clk, i_rst_n,
        r_valid && r_stage.dsr != '0 |-> r_stage.rem < r_stage.dsr)
    // backpressure only with a full stage
    `RUDU_ASSERT_ALL(a_ready_full, i_clk,
        !o_up_ready |-> r_valid)

endmodule

`default_nettype wire

// ===== hdl/restoring_unsigned_divider_unit.sv =====
// top level of the restoring unsigned divider: a chain of rudu_cell stages
// depends on rudu_pkg and rudu_cell
//
//  channel  | valid        | ready        | data
//  ---------+--------------+--------------+-------------
//  input    | i_in_valid   | o_in_ready   | i_in_data
//  output   | o_out_valid  | i_out_ready  | o_out_data
//
// one transaction per cycle sustained while i_out_ready stays high; one
// subtract-restore cell per quotient bit, the last cell register drives the output
// each cell has its own ready, so empty stages close up while the output stalls
// reset clears the cell valid bits only
`default_nettype none

module restoring_unsigned_divider_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rudu_pkg::t_div_in i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rudu_pkg::t_div_out     o_out_data
);

    logic             link_valid [rudu_pkg::DIV_W+1];
    logic             link_ready [rudu_pkg::DIV_W+1];
    rudu_pkg::t_stage link_stage [rudu_pkg::DIV_W+1];

    assign link_valid[0]     = i_in_valid;
    assign o_in_ready        = link_ready[0];
    assign link_stage[0].rem = '0;
    assign link_stage[0].quo = rudu_pkg::t_word'(i_in_data.dividend);
    assign link_stage[0].dsr = rudu_pkg::t_word'(i_in_data.divisor);

    for (genvar k = 0; k < rudu_pkg::DIV_W; k++) begin : g_cell
        rudu_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_up_valid (link_valid[k]),
            .o_up_ready (link_ready[k]),
            .i_up_stage (link_stage[k]),
            .o_dn_valid (link_valid[k+1]),
            .i_dn_ready (link_ready[k+1]),
            .o_dn_stage (link_stage[k+1])
        );
    end

    assign o_out_valid               = link_valid[rudu_pkg::DIV_W];
    assign link_ready[rudu_pkg::DIV_W] = i_out_ready;
    assign o_out_data.quotient  = rudu_pkg::t_field'(link_stage[rudu_pkg::DIV_W].quo);
    assign o_out_data.remainder = rudu_pkg::t_field'(link_stage[rudu_pkg::DIV_W].rem);

endmodule

`default_nettype wire
